// ===== rtl/tnbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tnbd_pkg
// Shared widths, field positions and command types for the busiest-days ranker.
// ----------------------------------------------------------------------------
`default_nettype none

package tnbd_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 12;
   localparam int DATE_W   = DAY_W + MONTH_W + YEAR_W;
   localparam int RANK_W   = 4;
   localparam int MSG_W    = 24;
   localparam int CSR_W    = 5;
   localparam int OUT_LIMIT = 16;

   // date word is {year, month, day}
   localparam int DAY_LSB   = 0;
   localparam int MONTH_LSB = DAY_W;
   localparam int YEAR_LSB  = DAY_W + MONTH_W;

   localparam logic [CSR_W-1:0] RANKS_RESET = CSR_W'(10);

   typedef enum logic {
      OP_MSG = 1'b0,
      OP_EOS = 1'b1
   } op_type;

   // what the back end has to do for one queued command
   typedef struct packed {
      logic file;     // file the closed day into the table
      logic report;   // then report the table
   } cmd_flags_type;

   localparam int FLAGS_W = $bits(cmd_flags_type);

endpackage

`default_nettype wire

// ===== rtl/top_n_busiest_days.sv =====
// ----------------------------------------------------------------------------
// top_n_busiest_days
// Counts messages per calendar day and keeps a ranked table of the busiest days.
// ----------------------------------------------------------------------------
//   channel  | handshake           | payload
//   ---------+---------------------+---------------------------------------------
//   req      | req_push / req_full | op, day, month, year
//   rsp      | rsp_pop / rsp_empty | rank, rank_day, rank_month, rank_year,
//            |                     | message_count, last
//   csr      | csr_we              | csr_wdata (ranks in use)
//
// Date items are taken one per cycle while the command queue is not full; a day change queues one table insert.
// End of stream: any open day is filed, then one result per cycle while rsp_pop is held for
// 1..16 ranks, paced by the single output register.
// A 4-entry command queue sits between the counter front end and the table; req_full
// rises only when it is full.
// Synchronous active-high reset clears the table, counts and queue; ranks = 10.
// ----------------------------------------------------------------------------
`default_nettype none

module top_n_busiest_days #(
   parameter int MAX_RANKS  = 16,
   parameter int COUNT_BITS = 24
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic                           req_op,
   input  wire logic [tnbd_pkg::DAY_W-1:0]     req_day,
   input  wire logic [tnbd_pkg::MONTH_W-1:0]   req_month,
   input  wire logic [tnbd_pkg::YEAR_W-1:0]    req_year,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [tnbd_pkg::RANK_W-1:0]         rsp_rank,
   output logic [tnbd_pkg::DAY_W-1:0]          rsp_rank_day,
   output logic [tnbd_pkg::MONTH_W-1:0]        rsp_rank_month,
   output logic [tnbd_pkg::YEAR_W-1:0]         rsp_rank_year,
   output logic [tnbd_pkg::MSG_W-1:0]          rsp_message_count,
   output logic                                rsp_last,
   input  wire logic                           csr_we,
   input  wire logic [tnbd_pkg::CSR_W-1:0]     csr_wdata
);

   import tnbd_pkg::*;

   localparam int Q_DEPTH = 4;
   localparam int Q_W     = FLAGS_W + DATE_W + COUNT_BITS;

   logic [CSR_W-1:0]      ranks_ff;
   logic                  req_accept;
   logic                  cmd_push;
   cmd_flags_type         push_flags;
   logic [DATE_W-1:0]     push_date;
   logic [COUNT_BITS-1:0] push_count;
   logic [Q_W-1:0]        pop_word;
   logic                  cmd_empty;
   logic                  cmd_pop;
   cmd_flags_type         pop_flags;
   logic [DATE_W-1:0]     pop_date;
   logic [COUNT_BITS-1:0] pop_count;
   logic [DATE_W-1:0]     out_date;

   always_ff @(posedge clock) begin
      if (reset) begin
         ranks_ff <= RANKS_RESET;
      end else if (csr_we) begin
         ranks_ff <= csr_wdata;
      end
   end

   assign req_accept = req_push && !req_full;

   tnbd_front #(
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .op        (req_op),
      .date      ({req_year, req_month, req_day}),
      .cmd_push  (cmd_push),
      .cmd_flags (push_flags),
      .cmd_date  (push_date),
      .cmd_count (push_count)
   );

   tnbd_queue #(
      .WIDTH (Q_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({push_flags, push_date, push_count}),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (pop_word),
      .empty     (cmd_empty)
   );

   assign {pop_flags, pop_date, pop_count} = pop_word;

   tnbd_back #(
      .MAX_RANKS  (MAX_RANKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .ranks_cfg (ranks_ff),
      .cmd_empty (cmd_empty),
      .cmd_flags (pop_flags),
      .cmd_date  (pop_date),
      .cmd_count (pop_count),
      .cmd_pop   (cmd_pop),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop),
      .out_rank  (rsp_rank),
      .out_date  (out_date),
      .out_count (rsp_message_count),
      .out_last  (rsp_last)
   );

   assign rsp_rank_day   = out_date[DAY_LSB +: DAY_W];
   assign rsp_rank_month = out_date[MONTH_LSB +: MONTH_W];
   assign rsp_rank_year  = out_date[YEAR_LSB +: YEAR_W];

endmodule

`default_nettype wire

// ===== rtl/tnbd_queue.sv =====
// ----------------------------------------------------------------------------
// tnbd_queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tnbd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count above depth");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ===== rtl/tnbd_front.sv =====
// ----------------------------------------------------------------------------
// tnbd_front
// Accepts date items, counts the open day's run and queues file/report work.
// ----------------------------------------------------------------------------
`default_nettype none

module tnbd_front #(
   parameter int COUNT_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic                          op,
   input  wire logic [tnbd_pkg::DATE_W-1:0]   date,
   output logic                               cmd_push,
   output tnbd_pkg::cmd_flags_type            cmd_flags,
   output logic [tnbd_pkg::DATE_W-1:0]        cmd_date,
   output logic [COUNT_BITS-1:0]              cmd_count
);

   import tnbd_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [DATE_W-1:0]     cur_date_ff, cur_date_in;
   logic [COUNT_BITS-1:0] run_cnt_ff, run_cnt_in;
   logic                  day_open;
   logic                  same_day;

   assign day_open  = (run_cnt_ff != '0);
   assign same_day  = day_open && (date == cur_date_ff);
   assign cmd_date  = cur_date_ff;
   assign cmd_count = run_cnt_ff;

   always_comb begin
      cur_date_in      = cur_date_ff;
      run_cnt_in       = run_cnt_ff;
      cmd_push         = 1'b0;
      cmd_flags.file   = day_open;
      cmd_flags.report = 1'b0;
      if (accept) begin
         case (op_type'(op))
            OP_MSG: begin
               if (same_day) begin
                  if (run_cnt_ff != COUNT_MAX) begin
                     run_cnt_in = run_cnt_ff + COUNT_BITS'(1);
                  end
               end else begin
                  cmd_push    = day_open;
                  cur_date_in = date;
                  run_cnt_in  = COUNT_BITS'(1);
               end
            end
            OP_EOS: begin
               cmd_push         = 1'b1;
               cmd_flags.report = 1'b1;
               cur_date_in      = '0;
               run_cnt_in       = '0;
            end
            default: begin
               cmd_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_date_ff <= '0;
         run_cnt_ff  <= '0;
      end else begin
         cur_date_ff <= cur_date_in;
         run_cnt_ff  <= run_cnt_in;
      end
   end

   a_msg_opens_day: assert property (@(posedge clock) disable iff (reset)
      (accept && op == OP_MSG) |=> run_cnt_ff != '0)
      else $error("message item left no day open");

endmodule

`default_nettype wire

// ===== rtl/tnbd_back.sv =====
// ----------------------------------------------------------------------------
// tnbd_back
// Ranked table with parallel compare-and-shift insertion, and the report walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tnbd_back #(
   parameter int MAX_RANKS  = 16,
   parameter int COUNT_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [tnbd_pkg::CSR_W-1:0]    ranks_cfg,
   input  wire logic                          cmd_empty,
   input  wire tnbd_pkg::cmd_flags_type       cmd_flags,
   input  wire logic [tnbd_pkg::DATE_W-1:0]   cmd_date,
   input  wire logic [COUNT_BITS-1:0]         cmd_count,
   output logic                               cmd_pop,
   output logic                               out_empty,
   input  wire logic                          out_pop,
   output logic [tnbd_pkg::RANK_W-1:0]        out_rank,
   output logic [tnbd_pkg::DATE_W-1:0]        out_date,
   output logic [tnbd_pkg::MSG_W-1:0]         out_count,
   output logic                               out_last
);

   import tnbd_pkg::*;

   localparam int LIMIT = (MAX_RANKS < OUT_LIMIT) ? MAX_RANKS : OUT_LIMIT;
   localparam int IDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
   localparam int CMP_W = 7;

   typedef enum logic {
      ST_IDLE,
      ST_REPORT
   } state_type;

   state_type             state_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [CSR_W-1:0]      n_ff;
   logic                  out_valid_ff;
   logic [RANK_W-1:0]     out_rank_ff;
   logic [DATE_W-1:0]     out_date_ff;
   logic [MSG_W-1:0]      out_count_ff;
   logic                  out_last_ff;

   logic [DATE_W-1:0]     tbl_date_ff [MAX_RANKS];
   logic [COUNT_BITS-1:0] tbl_cnt_ff  [MAX_RANKS];
   logic [DATE_W-1:0]     tbl_date_in [MAX_RANKS];
   logic [COUNT_BITS-1:0] tbl_cnt_in  [MAX_RANKS];

   logic [CSR_W-1:0]      n_act;
   logic [MAX_RANKS-1:0]  hit_pre;
   logic                  do_file;
   logic                  load_out;
   logic                  last_idx;
   logic [MSG_W-1:0]      cnt_ext;

   // clamp the ranks register to 1..LIMIT
   always_comb begin
      if (ranks_cfg == '0) begin
         n_act = CSR_W'(1);
      end else if (ranks_cfg > CSR_W'(LIMIT)) begin
         n_act = CSR_W'(LIMIT);
      end else begin
         n_act = ranks_cfg;
      end
   end

   assign cmd_pop = (state_ff == ST_IDLE) && !cmd_empty;
   assign do_file = cmd_pop && cmd_flags.file;

   // insertion: first active slot with a strictly smaller count takes the new day,
   // active slots after it take their upper neighbor, the bottom one drops out
   assign hit_pre[0] = 1'b0;

   for (genvar i = 0; i < MAX_RANKS; i++) begin : g_slot
      logic active;
      logic gt;
      assign active = (i < int'(n_act));
      assign gt     = active && (cmd_count > tbl_cnt_ff[i]);

      if (i < MAX_RANKS - 1) begin : g_chain
         assign hit_pre[i+1] = hit_pre[i] || gt;
      end

      if (i == 0) begin : g_top
         always_comb begin
            tbl_date_in[i] = tbl_date_ff[i];
            tbl_cnt_in[i]  = tbl_cnt_ff[i];
            if (gt) begin
               tbl_date_in[i] = cmd_date;
               tbl_cnt_in[i]  = cmd_count;
            end
         end
      end else begin : g_rest
         always_comb begin
            tbl_date_in[i] = tbl_date_ff[i];
            tbl_cnt_in[i]  = tbl_cnt_ff[i];
            if (active && hit_pre[i]) begin
               tbl_date_in[i] = tbl_date_ff[i-1];
               tbl_cnt_in[i]  = tbl_cnt_ff[i-1];
            end else if (gt) begin
               tbl_date_in[i] = cmd_date;
               tbl_cnt_in[i]  = cmd_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_RANKS; i++) begin
            tbl_date_ff[i] <= '0;
            tbl_cnt_ff[i]  <= '0;
         end
      end else if (do_file) begin
         for (int i = 0; i < MAX_RANKS; i++) begin
            tbl_date_ff[i] <= tbl_date_in[i];
            tbl_cnt_ff[i]  <= tbl_cnt_in[i];
         end
      end
   end

   // report walk
   assign load_out = (state_ff == ST_REPORT) && (!out_valid_ff || out_pop);
   assign last_idx = ((CMP_W'(idx_ff) + CMP_W'(1)) == CMP_W'(n_ff));
   assign cnt_ext  = MSG_W'(tbl_cnt_ff[idx_ff]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         n_ff         <= CSR_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_pop) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_pop && cmd_flags.report) begin
                  state_ff <= ST_REPORT;
                  idx_ff   <= '0;
                  n_ff     <= n_act;
               end
            end
            ST_REPORT: begin
               if (load_out) begin
                  if (last_idx) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     idx_ff <= idx_ff + IDX_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      if (load_out) begin
         out_rank_ff  <= RANK_W'(idx_ff);
         out_date_ff  <= tbl_date_ff[idx_ff];
         out_count_ff <= cnt_ext;
         out_last_ff  <= last_idx;
      end
   end

   assign out_empty = !out_valid_ff;
   assign out_rank  = out_rank_ff;
   assign out_date  = out_date_ff;
   assign out_count = out_count_ff;
   assign out_last  = out_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> (CMP_W'(idx_ff) < CMP_W'(n_ff)))
      else $error("report index past active ranks");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_pop) |=> ($stable(out_rank_ff) && $stable(out_date_ff)))
      else $error("waiting result item overwritten");

endmodule

`default_nettype wire

// ===== sim/tb_top_n_busiest_days.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_n_busiest_days
// Self-checking bench for the busiest-days ranker. Feeds message dates and
// end-of-stream items through the request queue. Predicts each ranked line in
// the bench. Checks every popped line field by field. Runs under several rank
// widths and under sender and receiver idling.
// ----------------------------------------------------------------------------

module tb_top_n_busiest_days;
   import tnbd_pkg::*;

   localparam int               RANKS_MAX     = 16;
   localparam logic [MSG_W-1:0] TALLY_MAX     = '1;
   localparam int               SETTLE_CYCLES = 32;
   localparam int               STALL_LIMIT   = 4000;
   localparam int               NUM_PHASES    = 6;
   localparam int               PHASE_ITEMS   = 40;

   typedef struct packed {
      op_type              op;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
   } date_item_type;

   typedef struct packed {
      logic [RANK_W-1:0]   rank;
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [MSG_W-1:0]    count;
      logic                last;
   } rank_line_type;

   typedef struct packed {
      logic [DAY_W-1:0]    day;
      logic [MONTH_W-1:0]  month;
      logic [YEAR_W-1:0]   year;
      logic [MSG_W-1:0]    count;
   } day_slot_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic                 req_op = 1'b0;
   logic [DAY_W-1:0]     req_day = '0;
   logic [MONTH_W-1:0]   req_month = '0;
   logic [YEAR_W-1:0]    req_year = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [RANK_W-1:0]    rsp_rank;
   logic [DAY_W-1:0]     rsp_rank_day;
   logic [MONTH_W-1:0]   rsp_rank_month;
   logic [YEAR_W-1:0]    rsp_rank_year;
   logic [MSG_W-1:0]     rsp_message_count;
   logic                 rsp_last;
   logic                 csr_we = 1'b0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   top_n_busiest_days u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_op            (req_op),
      .req_day           (req_day),
      .req_month         (req_month),
      .req_year          (req_year),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_rank          (rsp_rank),
      .rsp_rank_day      (rsp_rank_day),
      .rsp_rank_month    (rsp_rank_month),
      .rsp_rank_year     (rsp_rank_year),
      .rsp_message_count (rsp_message_count),
      .rsp_last          (rsp_last),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // stimulus and expected lines
   date_item_type  date_feed[$];
   rank_line_type  ranking_due[$];

   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   logic req_taken = 1'b0;

   int mismatches = 0;
   int items_sent = 0;
   int lines_checked = 0;
   int reports_seen = 0;
   int rank_settings = 1;
   int quiet_cycles = 0;

   // date walker for well-formed streams
   int gday = 1;
   int gmonth = 1;
   int gyear = 2000;

   // ---- predictor state ----
   logic [CSR_W-1:0]  ranks_cfg = RANKS_RESET;
   logic [DATE_W-1:0] open_date = '0;
   logic [MSG_W-1:0]  open_tally = '0;   // zero: no day open
   day_slot_type      board [RANKS_MAX];

   initial begin
      for (int i = 0; i < RANKS_MAX; i++)
         board[i] = '0;
   end

   function automatic int ranks_active();
      int n;
      n = int'(ranks_cfg);
      if (n < 1)
         n = 1;
      if (n > RANKS_MAX)
         n = RANKS_MAX;
      return n;
   endfunction

   // insert the closed day at the first slot with a strictly smaller count
   task automatic file_closed_day();
      int n;
      int i;
      int j;
      logic placed;
      n = ranks_active();
      placed = 1'b0;
      if (open_tally != '0) begin
         for (i = 0; i < n; i++) begin
            if (!placed && open_tally > board[i].count) begin
               for (j = n - 1; j > i; j--)
                  board[j] = board[j-1];
               board[i].day   = open_date[DAY_LSB +: DAY_W];
               board[i].month = open_date[MONTH_LSB +: MONTH_W];
               board[i].year  = open_date[YEAR_LSB +: YEAR_W];
               board[i].count = open_tally;
               placed = 1'b1;
            end
         end
      end
   endtask

   task automatic tally_date(input date_item_type it);
      logic [DATE_W-1:0] date;
      rank_line_type line;
      int n;
      int k;
      date = {it.year, it.month, it.day};
      if (it.op == OP_MSG) begin
         if (open_tally != '0 && date == open_date) begin
            if (open_tally != TALLY_MAX)
               open_tally = open_tally + 1'b1;
         end else begin
            file_closed_day();
            open_date  = date;
            open_tally = MSG_W'(1);
         end
      end else begin
         file_closed_day();
         open_date  = '0;
         open_tally = '0;
         n = ranks_active();
         for (k = 0; k < n; k++) begin
            line.rank  = k[RANK_W-1:0];
            line.day   = board[k].day;
            line.month = board[k].month;
            line.year  = board[k].year;
            line.count = board[k].count;
            line.last  = (k == n - 1);
            ranking_due.push_back(line);
         end
      end
   endtask

   task automatic report_mismatch(input string detail);
      $display("MISMATCH @%0t: %s", $time, detail);
      mismatches++;
   endtask

   task automatic check_line();
      rank_line_type want;
      if (ranking_due.size() == 0) begin
         report_mismatch($sformatf("line for rank %0d with nothing pending", rsp_rank));
      end else begin
         want = ranking_due.pop_front();
         if (rsp_rank !== want.rank)
            report_mismatch($sformatf("rank %0d, want %0d", rsp_rank, want.rank));
         if (rsp_rank_day !== want.day)
            report_mismatch($sformatf("rank %0d day %0d, want %0d",
                                      want.rank, rsp_rank_day, want.day));
         if (rsp_rank_month !== want.month)
            report_mismatch($sformatf("rank %0d month %0d, want %0d",
                                      want.rank, rsp_rank_month, want.month));
         if (rsp_rank_year !== want.year)
            report_mismatch($sformatf("rank %0d year %0d, want %0d",
                                      want.rank, rsp_rank_year, want.year));
         if (rsp_message_count !== want.count)
            report_mismatch($sformatf("rank %0d count %0d, want %0d",
                                      want.rank, rsp_message_count, want.count));
         if (rsp_last !== want.last)
            report_mismatch($sformatf("rank %0d last %0b, want %0b",
                                      want.rank, rsp_last, want.last));
         if (want.last)
            reports_seen++;
         lines_checked++;
      end
   endtask

   // ---- monitor: everything sampled at the rising edge ----
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            ranks_cfg = csr_wdata;
         req_taken <= req_push && !req_full;
         if (req_push && !req_full) begin
            tally_date('{op_type'(req_op), req_day, req_month, req_year});
            items_sent++;
         end
         if (rsp_pop && !rsp_empty)
            check_line();
      end
   end

   // ---- driver: inputs change at the falling edge ----
   always @(negedge clock) begin
      date_item_type it;
      if (reset) begin
         req_push <= 1'b0;
         rsp_pop  <= 1'b0;
      end else begin
         if (!req_push || req_taken) begin
            if (date_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               it = date_feed.pop_front();
               req_push  <= 1'b1;
               req_op    <= it.op;
               req_day   <= it.day;
               req_month <= it.month;
               req_year  <= it.year;
            end else begin
               req_push <= 1'b0;
            end
         end
         rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d lines still due",
                  quiet_cycles, ranking_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---- stimulus helpers ----
   task automatic add_item(input op_type op, input int d, input int m, input int y);
      date_item_type it;
      it.op    = op;
      it.day   = d[DAY_W-1:0];
      it.month = m[MONTH_W-1:0];
      it.year  = y[YEAR_W-1:0];
      date_feed.push_back(it);
   endtask

   task automatic add_run(input int len, input int d, input int m, input int y);
      repeat (len)
         add_item(OP_MSG, d, m, y);
   endtask

   task automatic advance_date();
      if ($urandom_range(9) == 0) begin
         // jump anywhere, may go backward in time
         gday   = $urandom_range(31, 1);
         gmonth = $urandom_range(12, 1);
         gyear  = $urandom_range(4095);
      end else begin
         gday += $urandom_range(3, 1);
         if (gday > 31) begin
            gday = 1;
            gmonth++;
            if (gmonth > 12) begin
               gmonth = 1;
               gyear  = (gyear + 1) % 4096;
            end
         end
      end
   endtask

   // streams of day runs closed by an end item, with some noise mixed in
   task automatic gen_streams(input int budget);
      int left;
      int days;
      int len;
      int roll;
      left = budget;
      while (left > 0) begin
         days = $urandom_range(10, 2);
         repeat (days) begin
            if (left > 0) begin
               roll = $urandom_range(99);
               if (roll < 10) begin
                  add_item(op_type'($urandom_range(1)), $urandom_range(31),
                           $urandom_range(15), $urandom_range(4095));
                  left--;
               end else begin
                  advance_date();
                  if (roll < 80)
                     len = $urandom_range(5, 1);
                  else if (roll < 95)
                     len = $urandom_range(20, 6);
                  else
                     len = $urandom_range(60, 30);
                  if (len > left)
                     len = left;
                  add_run(len, gday, gmonth, gyear);
                  left -= len;
               end
            end
         end
         add_item(OP_EOS, $urandom_range(31), $urandom_range(15), $urandom_range(4095));
         left--;
      end
   endtask

   // sender holds off until every due line is out and the block has settled
   task automatic wait_for_drain();
      while (date_feed.size() != 0 || req_push || ranking_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   task automatic write_ranks(input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value[CSR_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      rank_settings++;
   endtask

   initial begin : stimulus
      int p;
      int ranks;
      repeat (9)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty report, field extremes, a tie, back-to-back ends
      add_item(OP_EOS, 0, 0, 0);
      add_run(3, 31, 12, 4095);
      add_run(3, 1, 1, 0);          // same count as the day before: ranks below it
      add_run(1, 0, 0, 0);          // all-zero date is still a real day
      add_run(4, 31, 15, 4095);
      add_item(OP_EOS, 31, 15, 4095);
      add_item(OP_EOS, 0, 0, 0);    // no open day, table reported as is
      add_run(2, 5, 6, 2024);
      add_run(1, 6, 6, 2024);
      add_item(OP_EOS, 17, 9, 1234);

      for (p = 0; p < NUM_PHASES; p++) begin
         wait_for_drain();
         case (p)
            0: begin ranks = 16; send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin ranks = 1;  send_idle_pct = 66; pop_stall_pct = 0;  end
            2: begin ranks = 0;  send_idle_pct = 0;  pop_stall_pct = 66; end
            3: begin ranks = 31; send_idle_pct = 23; pop_stall_pct = 23; end
            4: begin ranks = $urandom_range(15, 2);  send_idle_pct = 66; pop_stall_pct = 0; end
            default: begin
               ranks = $urandom_range(30, 17);
               send_idle_pct = 0;
               pop_stall_pct = 66;
            end
         endcase
         write_ranks(ranks);
         gen_streams(PHASE_ITEMS);
      end

      pop_stall_pct = 0;
      send_idle_pct = 0;
      wait_for_drain();

      $display("Sent %0d date and end items under %0d rank settings and four idling mixes;",
               items_sent, rank_settings);
      $display("checked %0d ranked lines across %0d reports.", lines_checked, reports_seen);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== top_n_busiest_days.f =====
rtl/tnbd_pkg.sv
rtl/tnbd_queue.sv
rtl/tnbd_front.sv
rtl/tnbd_back.sv
rtl/top_n_busiest_days.sv
sim/tb_top_n_busiest_days.sv
